[rtl/core/deq_pkg.sv]
package deq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ENTRY_W = 11;

  // operation codes carried in the kind field; other codes act as a query
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_QUERY      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [1:0]               status;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } rsp_t;

endpackage

[rtl/core/deq_store.sv]
module deq_store #(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic signed [deq_pkg::WORD_W-1:0] wr_data,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic signed [deq_pkg::WORD_W-1:0] rd_data
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/double_ended_queue_core.sv]
// Results: push, query and refused operations are registered at acceptance; a pop
// that leaves words behind first reads the store's single registered read port
// (S_READ). Throughput: one item per cycle, but no item is taken while such a read
// or a result held back by rsp_stall (S_HOLD) is being finished.
// Reset: clears the end indices, the count and the handshake state; the word store
// is not cleared and needs no clearing pass, so items are taken right after reset.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  // Step a ring index forwards or backwards, wrapping at DEPTH.
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
  endfunction

  state_t state;

  // End indices: front_index is the slot of the front word, back_index the slot of
  // the back word. With nothing held, back_index sits one slot behind front_index.
  logic [AW-1:0] front_index;
  logic [AW-1:0] back_index;
  logic [CW-1:0] held_count;

  // Copies of the two end words, so that a pop needs no read for its own result
  // and only the newly exposed end has to come from the store.
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;

  // Parts of the result fixed at acceptance, kept until the result leaves
  logic signed [WORD_W-1:0] pend_popped;
  logic [1:0]               pend_status;
  logic                     fill_front;

  logic [AW-1:0]            front_next;
  logic [AW-1:0]            back_next;
  logic [CW-1:0]            count_next;
  logic signed [WORD_W-1:0] fword_next;
  logic signed [WORD_W-1:0] bword_next;
  logic signed [WORD_W-1:0] popped_next;
  logic [1:0]               status_next;
  logic                     fill_front_next;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;

  logic                     req_acc;
  logic                     out_free;
  logic                     rsp_load;
  logic                     is_full;
  logic                     is_none;
  logic signed [WORD_W-1:0] front_view;
  logic signed [WORD_W-1:0] back_view;
  rsp_t                     rsp_now;
  rsp_t                     rsp_view;

  deq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(req.push_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Items enter only from idle; a waiting result never blocks the next acceptance
  // except while the previous item is still being finished.
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign is_full   = (held_count == CW'(DEPTH));
  assign is_none   = (held_count == '0);

  // A new result goes into the output register at this edge
  assign rsp_load = out_free && ((state == S_IDLE && req_acc && !rd_en)
                                 || state == S_READ || state == S_HOLD);

  // Work out the effect of the offered item. The store is written at the edge that
  // accepts a push; a pop issues its read at that same edge. Every later pop reads
  // at a later edge than the push that filled its slot, so no forwarding is needed.
  always_comb begin
    front_next      = front_index;
    back_next       = back_index;
    count_next      = held_count;
    fword_next      = front_word;
    bword_next      = back_word;
    popped_next     = WORD_NONE;
    status_next     = ST_OK;
    fill_front_next = fill_front;
    wr_en           = 1'b0;
    wr_addr         = front_index;
    rd_en           = 1'b0;
    rd_addr         = front_index;
    unique case (req.kind)
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          front_next = idx_dec(front_index);
          wr_en      = req_acc;
          wr_addr    = front_next;
          fword_next = req.push_value;
          if (is_none) begin
            bword_next = req.push_value;
          end
          count_next = CW'(held_count + 1'b1);
        end
      end
      KIND_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          back_next  = idx_inc(back_index);
          wr_en      = req_acc;
          wr_addr    = back_next;
          bword_next = req.push_value;
          if (is_none) begin
            fword_next = req.push_value;
          end
          count_next = CW'(held_count + 1'b1);
        end
      end
      KIND_POP_FRONT: begin
        if (is_none) begin
          status_next = ST_POP_EMPTY;
        end else begin
          popped_next     = front_word;
          front_next      = idx_inc(front_index);
          count_next      = CW'(held_count - 1'b1);
          // fetch the word that becomes the front
          rd_en           = req_acc && (count_next != '0);
          rd_addr         = front_next;
          fill_front_next = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (is_none) begin
          status_next = ST_POP_EMPTY;
        end else begin
          popped_next     = back_word;
          back_next       = idx_dec(back_index);
          count_next      = CW'(held_count - 1'b1);
          // fetch the word that becomes the back
          rd_en           = req_acc && (count_next != '0);
          rd_addr         = back_next;
          fill_front_next = 1'b0;
        end
      end
      default: begin
        // query and unused codes leave everything as it is
      end
    endcase
  end

  // Result for an item that needs no read, built from the values after the item
  always_comb begin
    rsp_now.popped_value = popped_next;
    rsp_now.status       = status_next;
    rsp_now.entry_count  = ENTRY_W'(count_next);
    rsp_now.is_empty     = (count_next == '0);
    rsp_now.front_value  = (count_next == '0) ? WORD_NONE : fword_next;
    rsp_now.back_value   = (count_next == '0) ? WORD_NONE : bword_next;
  end

  // While the read is returning, substitute the fetched word for the exposed end
  assign front_view = (state == S_READ && fill_front) ? rd_data : front_word;
  assign back_view  = (state == S_READ && !fill_front) ? rd_data : back_word;

  always_comb begin
    rsp_view.popped_value = pend_popped;
    rsp_view.status       = pend_status;
    rsp_view.entry_count  = ENTRY_W'(held_count);
    rsp_view.is_empty     = is_none;
    rsp_view.front_value  = is_none ? WORD_NONE : front_view;
    rsp_view.back_value   = is_none ? WORD_NONE : back_view;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      back_index  <= AW'(DEPTH - 1);
      held_count  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // drop the output once it has been taken, unless a new result loads below
      if (!rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            front_index <= front_next;
            back_index  <= back_next;
            held_count  <= count_next;
            front_word  <= fword_next;
            back_word   <= bword_next;
            pend_popped <= popped_next;
            pend_status <= status_next;
            fill_front  <= fill_front_next;
            if (rd_en) begin
              state <= S_READ;
            end else if (out_free) begin
              rsp_valid <= 1'b1;
              rsp       <= rsp_now;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_READ: begin
          // capture the fetched end word, then hand over or hold the result
          front_word <= front_view;
          back_word  <= back_view;
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_view;
            state     <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_view;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never exceeds the store depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("held count beyond store depth");

  // An accepted item moves the count by at most one.
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (held_count == $past(held_count)
                 || held_count == CW'($past(held_count) + 1'b1)
                 || CW'(held_count + 1'b1) == $past(held_count)))
    else $error("count moved by more than one");

  // With nothing held, the back index sits just behind the front index.
  a_ring_empty : assert property (@(posedge clk) disable iff (rst)
    is_none |-> (back_index == idx_dec(front_index)))
    else $error("end indices out of step on an empty queue");

  // The store is never written while full.
  a_no_write_full : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !is_full)
    else $error("store written while full");

  // A returning read with a free output delivers its result at the next edge.
  a_read_delivers : assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && !rsp_valid) |=> rsp_valid)
    else $error("result lost after store read");

endmodule

[test/tb_double_ended_queue_core.sv]
module tb_double_ended_queue_core;
  import deq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 1024;
  // cycles with no handshake on either side before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // cycles to linger once every result is in
  localparam int unsigned DRAIN_CYCLES = 8;

  // Mirror of the deque: its own copy of the circular store, the front slot
  // and the count, plus the results each accepted item should produce.
  class deque_mirror;
    logic signed [WORD_W-1:0] words [QUEUE_DEPTH];
    int unsigned head = 0;
    int unsigned held = 0;
    rsp_t due_results[$];
    int unsigned checked = 0;
    int unsigned errors = 0;

    task flag_mismatch(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Work out the result of one accepted item and advance the mirror.
    function void take_item(req_t item);
      rsp_t r;
      r.popped_value = WORD_NONE;
      r.status       = ST_OK;
      r.front_value  = WORD_NONE;
      r.back_value   = WORD_NONE;
      case (item.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held == QUEUE_DEPTH) begin
            r.status = ST_PUSH_FULL;
          end else if (item.kind == KIND_PUSH_FRONT) begin
            head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            words[head] = item.push_value;
            held++;
          end else begin
            words[(head + held) % QUEUE_DEPTH] = item.push_value;
            held++;
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_POP_EMPTY;
          end else if (item.kind == KIND_POP_FRONT) begin
            r.popped_value = words[head];
            head = (head + 1) % QUEUE_DEPTH;
            held--;
          end else begin
            r.popped_value = words[(head + held - 1) % QUEUE_DEPTH];
            held--;
          end
        end
        default: begin
        end
      endcase
      if (held != 0) begin
        r.front_value = words[head];
        r.back_value  = words[(head + held - 1) % QUEUE_DEPTH];
      end
      r.entry_count = ENTRY_W'(held);
      r.is_empty    = (held == 0);
      due_results = {due_results, r};
    endfunction

    // Compare one accepted result with the oldest outstanding one.
    task match_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      check_field("popped_value", got.popped_value, want.popped_value);
      check_field("status", WORD_W'(got.status), WORD_W'(want.status));
      check_field("entry_count", WORD_W'(got.entry_count), WORD_W'(want.entry_count));
      check_field("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
      check_field("front_value", got.front_value, want.front_value);
      check_field("back_value", got.back_value, want.back_value);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // idle chances in percent, changed by the stimulus between phases
  int unsigned send_idle = 22;
  int unsigned recv_idle = 45;

  deque_mirror mirror = new;

  always #10 clk = ~clk;

  double_ended_queue_core #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Offer one item, idling first at random, and hold it until the block takes it.
  // Valid stays high from one item to the next unless a gap is drawn, so it is
  // never dropped and raised again in the same step.
  task automatic send_op(logic [2:0] kind, logic [WORD_W-1:0] value);
    req_t item;
    item.kind       = kind;
    item.push_value = value;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    // accepted at this edge: note it before its result can turn up
    mirror.take_item(item);
  endtask

  // Mostly random words, with the extremes drawn now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Weighted choice of operation; the remainder goes to the query codes, the
  // unused ones included.
  function automatic logic [2:0] pick_kind(int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    if (roll < push_pct + pop_pct) return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
    return KIND_QUERY + 3'($urandom_range(3));
  endfunction

  // Take results with random back-pressure; check each one the block hands over.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) mirror.match_result(rsp);
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: pops on an empty queue, every query code, pushes of the
    // extreme words at both ends (the first front push wraps below slot zero),
    // then drain from both ends until empty and pop once more.
    send_op(KIND_POP_FRONT, 32'h1234_5678);
    send_op(KIND_POP_BACK, 32'hffff_ffff);
    send_op(KIND_QUERY, 32'h0000_0000);
    send_op(KIND_QUERY + 3'd1, 32'hffff_ffff);
    send_op(KIND_QUERY + 3'd2, 32'h8000_0000);
    send_op(KIND_QUERY + 3'd3, 32'h7fff_ffff);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_PUSH_BACK, 32'h7fff_ffff);
    send_op(KIND_PUSH_FRONT, 32'hffff_ffff);
    send_op(KIND_PUSH_BACK, 32'h0000_0000);
    send_op(KIND_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(KIND_PUSH_BACK, 32'h5555_5555);
    send_op(KIND_QUERY, 32'hffff_ffff);
    send_op(KIND_POP_BACK, 32'hffff_ffff);
    send_op(KIND_POP_FRONT, 32'h0000_0000);
    send_op(KIND_POP_BACK, 32'h5a5a_5a5a);
    send_op(KIND_POP_FRONT, 32'ha5a5_a5a5);
    send_op(KIND_POP_FRONT, 32'h0000_0000);
    send_op(KIND_POP_BACK, 32'h0000_0000);
    send_op(KIND_POP_BACK, 32'h0000_0000);
    // single word: front and back are the same slot
    send_op(KIND_PUSH_BACK, 32'h0000_0001);
    send_op(KIND_POP_FRONT, 32'h0000_0000);
    send_op(KIND_PUSH_FRONT, 32'hffff_fffe);
    send_op(KIND_POP_BACK, 32'h0000_0000);

    // Mixed traffic at low occupancy, so empty pops keep turning up.
    repeat (60) send_op(pick_kind(40, 45), pick_word());

    // Swap the idle chances and fill the store, then hammer it while full.
    send_idle = 45;
    recv_idle = 22;
    while (mirror.held < QUEUE_DEPTH) send_op(pick_kind(95, 3), pick_word());
    repeat (40) send_op(pick_kind(60, 30), pick_word());

    // No idling: back-to-back items, pops biased to exercise the slow path.
    send_idle = 0;
    recv_idle = 0;
    repeat (60) send_op(pick_kind(30, 60), pick_word());
    req_valid <= 1'b0;

    // Wait for the outstanding results, then linger a little for strays.
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.due_results.size() != 0)
      mirror.flag_mismatch($sformatf("%0d results never arrived", mirror.due_results.size()));

    if (mirror.errors == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
